// ----- rtl/core/sms_pkg.sv -----
// Shared types and constants for the smoothstep alpha matte block.
`timescale 1ns / 1ps

package sms_pkg;

    // Q0.16 scale; one needs 17 bits and three needs 18 bits to be representable
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] HALF_Q16  = 16'd32768;
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    localparam logic [7:0]  ALPHA_MAX = 8'd255;
    localparam logic [7:0]  ALPHA_MIN = 8'd0;

    localparam logic [16:0] THRESHOLD_RESET = 17'd32768;
    localparam logic [15:0] SOFTNESS_RESET  = 16'd0;

    // register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_SOFTNESS  = 1'b1;

    localparam int LUT_DEPTH = 256;
    localparam int LUT_AW    = $clog2(LUT_DEPTH);

    // rounding constant for the Q0.48 -> 8 bit scale
    localparam logic [57:0] ROUND_HALF = 58'd1 << 47;

    typedef struct packed {
        logic              en;
        logic [LUT_AW-1:0] addr;
        logic [7:0]        data;
    } t_lut_wr;

    // mask/255 rounded to nearest in Q0.16: m*65536 = m*257*255 + m
    function automatic logic [16:0] mask_to_q16(input logic [7:0] m);
        logic [16:0] base;
        base = 17'(m) * 17'd257;
        return base + 17'(m[7]);
    endfunction

endpackage

// ----- rtl/core/sms_pix_in_if.sv -----
// Pixel input channel: mask sample plus original RGB.
`timescale 1ns / 1ps

interface sms_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_value;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, mask_value, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, mask_value, red_in, green_in, blue_in, output ready);
endinterface

// ----- rtl/core/sms_pix_out_if.sv -----
// Pixel output channel: refined alphas plus passed-through RGB.
`timescale 1ns / 1ps

interface sms_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_alpha;
    logic [7:0] background_alpha;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, mask_alpha, background_alpha, red_out, green_out, blue_out,
                    input ready);
    modport sink   (input valid, mask_alpha, background_alpha, red_out, green_out, blue_out,
                    output ready);
endinterface

// ----- rtl/core/sms_lut.sv -----
// Alpha lookup memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sms_lut (
    input  logic                        i_clk,
    input  sms_pkg::t_lut_wr            i_wr,
    input  logic                        i_rd_en,
    input  logic [sms_pkg::LUT_AW-1:0]  i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [sms_pkg::LUT_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/sms_fill.sv -----
// Table builder: evaluates the smoothstep for every mask code and writes the alpha table.
`timescale 1ns / 1ps

module sms_fill (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [16:0]      i_threshold,
    input  logic [15:0]      i_softness,
    output sms_pkg::t_lut_wr o_wr,
    output logic             o_ready
);

    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_PREP, S_SPAN, S_EVAL, S_DIV, S_MUL1, S_MUL2, S_ROUND, S_DONE
    } t_fill_state;

    t_fill_state r_state;
    sms_pkg::t_lut_wr r_wr;

    logic [16:0] r_lower;
    logic [16:0] r_upper;
    logic [16:0] r_den;
    logic        r_empty;
    logic [sms_pkg::LUT_AW-1:0] r_entry;
    logic [16:0] r_rem;
    logic [15:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0] r_sq;
    logic [17:0] r_w;
    logic [49:0] r_s;

    logic [16:0] w_thr;
    logic [15:0] w_soft;
    logic [17:0] w_sum;
    logic [16:0] w_v;
    logic [17:0] w_rem2;
    logic [57:0] w_scaled;
    logic        w_last;

    always_comb begin
        w_thr    = (i_threshold > sms_pkg::ONE_Q16) ? sms_pkg::ONE_Q16 : i_threshold;
        w_soft   = (i_softness > sms_pkg::HALF_Q16) ? sms_pkg::HALF_Q16 : i_softness;
        w_sum    = 18'(w_thr) + 18'(w_soft);
        w_v      = sms_pkg::mask_to_q16(r_entry);
        w_rem2   = {r_rem, 1'b0};
        // s*255 + half, scaled back by 2^48
        w_scaled = {r_s, 8'b0} - 58'(r_s) + sms_pkg::ROUND_HALF;
        w_last   = (r_entry == sms_pkg::LUT_AW'(sms_pkg::LUT_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= S_PREP;
            r_wr    <= '0;
        end else begin
            unique case (r_state)
                S_PREP: begin
                    r_wr.en <= 1'b0;
                    r_lower <= (w_thr > 17'(w_soft)) ? (w_thr - 17'(w_soft)) : 17'd0;
                    r_upper <= (w_sum > 18'(sms_pkg::ONE_Q16)) ? sms_pkg::ONE_Q16
                                                               : w_sum[16:0];
                    r_entry <= '0;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_wr.en <= 1'b0;
                    r_den   <= r_upper - r_lower;
                    r_empty <= (r_upper <= r_lower);
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_wr.addr <= r_entry;
                    if (r_empty || w_v <= r_lower || w_v >= r_upper) begin
                        // hard step, or outside the transition band
                        r_wr.en   <= 1'b1;
                        r_wr.data <= (w_v >= r_upper) ? sms_pkg::ALPHA_MAX
                                                      : sms_pkg::ALPHA_MIN;
                        r_entry   <= r_entry + 1'b1;
                        r_state   <= w_last ? S_DONE : S_EVAL;
                    end else begin
                        r_wr.en <= 1'b0;
                        r_rem   <= w_v - r_lower;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_wr.en <= 1'b0;
                    // restoring division, one quotient bit per cycle
                    if (w_rem2 >= 18'(r_den)) begin
                        r_rem <= 17'(w_rem2 - 18'(r_den));
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[16:0];
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_wr.en <= 1'b0;
                    r_sq    <= 32'(r_quo) * 32'(r_quo);
                    r_w     <= sms_pkg::THREE_Q16 - {1'b0, r_quo, 1'b0};
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_wr.en <= 1'b0;
                    r_s     <= 50'(r_sq) * 50'(r_w);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_wr.en   <= 1'b1;
                    r_wr.data <= w_scaled[55:48];
                    r_entry   <= r_entry + 1'b1;
                    r_state   <= w_last ? S_DONE : S_EVAL;
                end
                S_DONE: begin
                    r_wr.en <= 1'b0;
                    r_state <= S_DONE;
                end
                default: begin
                    r_wr.en <= 1'b0;
                    r_state <= S_PREP;
                end
            endcase
        end
    end

    assign o_wr    = r_wr;
    // hold off reads until the final table write has landed
    assign o_ready = (r_state == S_DONE) && !r_wr.en;

endmodule

// ----- rtl/core/smoothstep_mask_alpha_split.sv -----
// Top level: config registers, alpha table lookup pipeline and output register.
// An accepted item passes the table read register, then the output register.
// Throughput: one item per cycle while the output accepts and no rebuild runs, limited by
// the single read port of the alpha table. Reset (synchronous, active low) sets threshold to
// 32768 and softness to 0, then rebuilds the 256-entry table with at most 254 entries in band.
// Every config write starts the same rebuild; input ready stays low until it completes.
`timescale 1ns / 1ps

module smoothstep_mask_alpha_split (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sms_pix_in_if.sink    i_pix,
    sms_pix_out_if.source o_pix,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [16:0] r_threshold;
    logic [15:0] r_softness;

    logic        w_cfg_wr;
    logic        w_fill_ready;
    logic        w_adv_out;
    logic        w_in_ready;
    logic        w_load;
    logic [7:0]  w_lut_data;
    sms_pkg::t_lut_wr w_lut_wr;

    logic        r_s1_valid;
    logic [7:0]  r_s1_red;
    logic [7:0]  r_s1_green;
    logic [7:0]  r_s1_blue;

    logic        r_out_valid;
    logic [7:0]  r_out_alpha;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= sms_pkg::THRESHOLD_RESET;
            r_softness  <= sms_pkg::SOFTNESS_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                sms_pkg::REG_THRESHOLD: r_threshold <= pwdata[16:0];
                sms_pkg::REG_SOFTNESS:  r_softness  <= pwdata[15:0];
                default:                r_threshold <= r_threshold;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sms_pkg::REG_THRESHOLD: prdata = 32'(r_threshold);
            sms_pkg::REG_SOFTNESS:  prdata = 32'(r_softness);
            default:                prdata = '0;
        endcase
    end

    sms_fill u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_cfg_wr),
        .i_threshold (r_threshold),
        .i_softness  (r_softness),
        .o_wr        (w_lut_wr),
        .o_ready     (w_fill_ready)
    );

    sms_lut u_lut (
        .i_clk     (i_clk),
        .i_wr      (w_lut_wr),
        .i_rd_en   (w_load),
        .i_rd_addr (i_pix.mask_value),
        .o_rd_data (w_lut_data)
    );

    assign w_adv_out   = !r_out_valid || o_pix.ready;
    assign w_in_ready  = w_fill_ready && (!r_s1_valid || w_adv_out);
    assign w_load      = i_pix.valid && w_in_ready;
    assign i_pix.ready = w_in_ready;

    // read stage: table data register sits inside the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_s1_valid <= i_pix.valid;
        end else if (w_adv_out) begin
            r_s1_valid <= 1'b0;
        end
        if (w_load) begin
            r_s1_red   <= i_pix.red_in;
            r_s1_green <= i_pix.green_in;
            r_s1_blue  <= i_pix.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_adv_out && r_s1_valid) begin
            r_out_alpha <= w_lut_data;
            r_out_red   <= r_s1_red;
            r_out_green <= r_s1_green;
            r_out_blue  <= r_s1_blue;
        end
    end

    assign o_pix.valid            = r_out_valid;
    assign o_pix.mask_alpha       = r_out_alpha;
    assign o_pix.background_alpha = sms_pkg::ALPHA_MAX - r_out_alpha;
    assign o_pix.red_out          = r_out_red;
    assign o_pix.green_out        = r_out_green;
    assign o_pix.blue_out         = r_out_blue;

endmodule

// ----- rtl/core/sms_checker.sv -----
// Port-level checks for the smoothstep alpha matte, bound to the top level.
`timescale 1ns / 1ps

module sms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_mask_alpha,
    input logic [7:0] i_background_alpha,
    input logic       i_psel,
    input logic       i_penable,
    input logic       i_pwrite
);

    // a pending result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    // the two alphas always sum to full scale
    a_alpha_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_background_alpha == 8'd255 - i_mask_alpha))
        else $error("background alpha is not the complement of mask alpha");

    // output valid must be high where an accepted item would reach the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("accepted item missing at output");

    // a config write rebuilds the table, so input is held off right after it
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite |=> !i_in_ready)
        else $error("input accepted while alpha table is being rebuilt");

endmodule

bind smoothstep_mask_alpha_split sms_checker u_sms_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_pix.valid),
    .i_in_ready         (i_pix.ready),
    .i_out_valid        (o_pix.valid),
    .i_out_ready        (o_pix.ready),
    .i_mask_alpha       (o_pix.mask_alpha),
    .i_background_alpha (o_pix.background_alpha),
    .i_psel             (psel),
    .i_penable          (penable),
    .i_pwrite           (pwrite)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for the smoothstep alpha matte block: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 40000;  // covers a table rebuild plus long stalls
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 4;      // covers the table read and output registers

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] bg_alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sms_pix_in_if  pix_in ();
    sms_pix_out_if pix_out ();

    smoothstep_mask_alpha_split u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the matte settings, as last written
    logic [16:0] threshold_cfg;
    logic [15:0] softness_cfg;

    t_pixel pending_pixels[$];
    int     mismatch_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_left;
    int     quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Expected foreground alpha for one mask sample under the current settings.
    function automatic logic [7:0] matte_alpha(input logic [7:0] mask);
        longint unsigned thr, soft_lim, lo, hi, v, t, s;
        thr      = (threshold_cfg > sms_pkg::ONE_Q16) ? 64'(sms_pkg::ONE_Q16)
                                                      : 64'(threshold_cfg);
        soft_lim = (softness_cfg > sms_pkg::HALF_Q16) ? 64'(sms_pkg::HALF_Q16)
                                                      : 64'(softness_cfg);
        lo       = (thr > soft_lim) ? thr - soft_lim : 0;
        hi       = thr + soft_lim;
        if (hi > 64'(sms_pkg::ONE_Q16)) begin
            hi = 64'(sms_pkg::ONE_Q16);
        end
        v = (64'(mask) * 65536 + 127) / 255;
        // empty transition collapses to a hard step
        if (hi <= lo) begin
            return (v >= hi) ? sms_pkg::ALPHA_MAX : sms_pkg::ALPHA_MIN;
        end
        if (v <= lo) begin
            t = 0;
        end else begin
            t = (v - lo) * 65536 / (hi - lo);
            if (t > 64'(sms_pkg::ONE_Q16)) begin
                t = 64'(sms_pkg::ONE_Q16);
            end
        end
        s = t * t * (64'(sms_pkg::THREE_Q16) - 2 * t);
        return 8'((s * 255 + (64'd1 << 47)) >> 48);
    endfunction

    function automatic t_pixel matte_pixel(input logic [7:0] mask, r, g, b);
        t_pixel px;
        px.alpha    = matte_alpha(mask);
        px.bg_alpha = sms_pkg::ALPHA_MAX - px.alpha;
        px.red      = r;
        px.green    = g;
        px.blue     = b;
        return px;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_pixel(input logic [7:0] mask, r, g, b);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.mask_value <= mask;
        pix_in.red_in     <= r;
        pix_in.green_in   <= g;
        pix_in.blue_in    <= b;
        do @(posedge i_clk); while (!pix_in.ready);
        pending_pixels.push_back(matte_pixel(mask, r, g, b));
        @(negedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle then access cycle; the block is drained first.
    task automatic write_reg(input logic sel, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == sms_pkg::REG_THRESHOLD) begin
            threshold_cfg = value[16:0];
        end else begin
            softness_cfg = value[15:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_matte(input logic [16:0] thr, input logic [15:0] soft_val);
        write_reg(sms_pkg::REG_THRESHOLD, 32'(thr));
        write_reg(sms_pkg::REG_SOFTNESS, 32'(soft_val));
    endtask

    // Mask extremes and the middle pair, with channel patterns rotated through.
    task automatic send_probe_set();
        logic [7:0] masks[4];
        logic [7:0] chans[4];
        masks = '{8'd0, 8'd127, 8'd128, 8'd255};
        chans = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        for (int k = 0; k < 4; k++) begin
            send_pixel(masks[k], chans[k], chans[(k + 1) % 4], chans[(k + 2) % 4]);
        end
    endtask

    task automatic test_reset_setting();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_probe_set();
        send_pixel(8'd200, 8'd1, 8'd2, 8'd3);
    endtask

    task automatic test_transition_edges();
        // zero threshold, no softness: every sample is at or above the step
        set_matte(17'd0, 16'd0);
        send_probe_set();
        // threshold at one: only full mask passes
        set_matte(sms_pkg::ONE_Q16, 16'd0);
        send_probe_set();
        // threshold and softness past their ranges: clamped to one and one half
        set_matte(17'h1FFFF, 16'hFFFF);
        send_probe_set();
        // widest smooth ramp
        set_matte(17'd32768, sms_pkg::HALF_Q16);
        send_probe_set();
    endtask

    task automatic pick_random_setting();
        case ($urandom_range(3))
            0: set_matte(17'($urandom_range(65536)), 16'($urandom_range(4096)));
            1: set_matte(17'($urandom_range(65536)), 16'd0);
            2: set_matte(17'($urandom_range(17'h1FFFF)), 16'($urandom_range(16'hFFFF)));
            default: set_matte(17'($urandom_range(65536)), 16'($urandom_range(32768)));
        endcase
    endtask

    task automatic test_random_stream();
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{76, 0}, '{0, 76}, '{35, 35}};
        for (int ph = 0; ph < 4; ph++) begin
            for (int sub = 0; sub < 2; sub++) begin
                pick_random_setting();
                send_idle_pct  = idle_mix[ph][0];
                recv_stall_pct = idle_mix[ph][1];
                repeat (60) send_random_pixel();
            end
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        pick_random_setting();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // the first item waits out the table rebuild before the hold-off starts
        send_random_pixel();
        hold_off_left  = 300;
        repeat (39) send_random_pixel();
    endtask

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pixel got;
        t_pixel want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            got = '{pix_out.mask_alpha, pix_out.background_alpha,
                    pix_out.red_out, pix_out.green_out, pix_out.blue_out};
            if (pending_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected item %h", got));
            end else begin
                want = pending_pixels.pop_front();
                if (got.alpha !== want.alpha || got.bg_alpha !== want.bg_alpha ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    note_mismatch($sformatf(
                        "alpha/bg/r/g/b expected %h/%h/%h/%h/%h got %h/%h/%h/%h/%h",
                        want.alpha, want.bg_alpha, want.red, want.green, want.blue,
                        got.alpha, got.bg_alpha, got.red, got.green, got.blue));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_in.valid      = 1'b0;
        pix_in.mask_value = '0;
        pix_in.red_in     = '0;
        pix_in.green_in   = '0;
        pix_in.blue_in    = '0;
        pix_out.ready     = 1'b0;
        threshold_cfg     = sms_pkg::THRESHOLD_RESET;
        softness_cfg      = sms_pkg::SOFTNESS_RESET;
        mismatch_count    = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_off_left     = 0;
        quiet_cycles      = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_setting();
        test_transition_edges();
        test_random_stream();
        test_output_backpressure();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sms_pkg.sv
rtl/core/sms_pix_in_if.sv
rtl/core/sms_pix_out_if.sv
rtl/core/sms_lut.sv
rtl/core/sms_fill.sv
rtl/core/smoothstep_mask_alpha_split.sv
rtl/core/sms_checker.sv
tb/sv/tb_top.sv
